// File: hdl/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg
// Types and constants shared by the table interpolator files.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int KEY_W  = 16;
  localparam int VAL_W  = 16;
  localparam int DIFF_W = KEY_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int DEN_W  = KEY_W;
  localparam int DIV_W  = PROD_W - 1;
  localparam int RES_W  = DIV_W + 2;

  localparam logic signed [RES_W-1:0] SAT_MAX = RES_W'(32767);
  localparam logic signed [RES_W-1:0] SAT_MIN = -RES_W'(32768);

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_EXACT   = 3'd0,
    ST_INTERP  = 3'd1,
    ST_OOB     = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_LOADED  = 3'd4,
    ST_FULL    = 3'd5,
    ST_CLEARED = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_DIVST,
    S_DIV,
    S_RES,
    S_FIN
  } state_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] val;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } mem_wr_t;

endpackage

// File: hdl/tli_in_if.sv
// ----------------------------------------------------------------------------
// tli_in_if
// Input channel: command, angle and coefficient with valid/ready.
// ----------------------------------------------------------------------------
interface tli_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic signed [15:0] angle;
  logic signed [15:0] coeff_in;

  modport source (output valid, output cmd, output angle, output coeff_in, input ready);
  modport sink (input valid, input cmd, input angle, input coeff_in, output ready);
endinterface

// File: hdl/tli_out_if.sv
// ----------------------------------------------------------------------------
// tli_out_if
// Result channel: coefficient and status with valid/ready.
// ----------------------------------------------------------------------------
interface tli_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] coeff_out;
  logic [2:0]         status;

  modport source (output valid, output coeff_out, output status, input ready);
  modport sink (input valid, input coeff_out, input status, output ready);
endinterface

// File: hdl/table_linear_interpolator.sv
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Piecewise linear table lookup over signed Q8.8 keys and Q4.12 values.
// ----------------------------------------------------------------------------
//   channel  direction  payload               handshake
//   in_ch    input      cmd, angle, coeff_in  valid/ready
//   out_ch   output     coeff_out, status     valid/ready
//
// A load, a clear or a query that ends early goes from S_IDLE straight to
// S_FIN. An exact match scans the table, then passes S_MUL on its way to S_FIN.
// An interpolating query does one table memory read per entry, then a multiply
// and a bit-serial division. Reset empties the table; no clearing pass is needed.
// The result waits in an output register, so a stalled result channel stalls
// only the next item.
// ----------------------------------------------------------------------------
module table_linear_interpolator (
  input  logic     clk,
  input  logic     rst_n,
  tli_in_if.sink   in_ch,
  tli_out_if.source out_ch
);
  import tli_pkg::*;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [KEY_W-1:0] min_r, min_nxt;
  logic signed [KEY_W-1:0] max_r, max_nxt;
  logic signed [KEY_W-1:0] query_r, query_nxt;
  logic [CNT_W-1:0]        issue_r, issue_nxt;
  logic                    pend_r, pend_nxt;
  logic                    ex_ok_r, ex_ok_nxt;
  logic signed [VAL_W-1:0] ex_val_r, ex_val_nxt;
  logic                    lo_ok_r, lo_ok_nxt;
  logic signed [KEY_W-1:0] lo_key_r, lo_key_nxt;
  logic signed [VAL_W-1:0] lo_val_r, lo_val_nxt;
  logic                    hi_ok_r, hi_ok_nxt;
  logic signed [KEY_W-1:0] hi_key_r, hi_key_nxt;
  logic signed [VAL_W-1:0] hi_val_r, hi_val_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [DEN_W-1:0]        den_r, den_nxt;
  logic                    neg_r, neg_nxt;
  logic signed [VAL_W-1:0] res_coeff_r, res_coeff_nxt;
  status_e                 res_status_r, res_status_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_coeff_r, out_coeff_nxt;
  status_e                 out_status_r, out_status_nxt;

  mem_wr_t                 mem_wr;
  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  entry_t                  rd_data;
  logic                    div_start;
  logic [DIV_W-1:0]        div_dividend;
  logic                    div_done;
  logic [DIV_W-1:0]        div_quot;

  logic                    accept;
  logic                    slot_free;
  logic signed [DIFF_W-1:0] dq_w, dv_w, dk_w;
  logic signed [PROD_W-1:0] prod_neg_w;
  logic [DIV_W-1:0]        mag_w;
  logic signed [RES_W-1:0] q_w, sum_w;

  tli_table_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tli_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    query_nxt      = query_r;
    issue_nxt      = issue_r;
    pend_nxt       = 1'b0;
    ex_ok_nxt      = ex_ok_r;
    ex_val_nxt     = ex_val_r;
    lo_ok_nxt      = lo_ok_r;
    lo_key_nxt     = lo_key_r;
    lo_val_nxt     = lo_val_r;
    hi_ok_nxt      = hi_ok_r;
    hi_key_nxt     = hi_key_r;
    hi_val_nxt     = hi_val_r;
    prod_nxt       = prod_r;
    den_nxt        = den_r;
    neg_nxt        = neg_r;
    res_coeff_nxt  = res_coeff_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_coeff_nxt  = out_coeff_r;
    out_status_nxt = out_status_r;

    mem_wr.en        = 1'b0;
    mem_wr.addr      = count_r[ADDR_W-1:0];
    mem_wr.data.key  = in_ch.angle;
    mem_wr.data.val  = in_ch.coeff_in;
    rd_en            = 1'b0;
    rd_addr          = issue_r[ADDR_W-1:0];
    div_start        = 1'b0;

    dq_w       = DIFF_W'(query_r) - DIFF_W'(lo_key_r);
    dv_w       = DIFF_W'(hi_val_r) - DIFF_W'(lo_val_r);
    dk_w       = DIFF_W'(hi_key_r) - DIFF_W'(lo_key_r);
    prod_neg_w = -prod_r;
    mag_w      = prod_r[PROD_W-1] ? prod_neg_w[DIV_W-1:0] : prod_r[DIV_W-1:0];
    div_dividend = mag_w + DIV_W'(den_r[DEN_W-1:1]);
    q_w        = neg_r ? -$signed({2'b00, div_quot}) : $signed({2'b00, div_quot});
    sum_w      = RES_W'(lo_val_r) + q_w;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_coeff_nxt = '0;
          unique case (in_ch.cmd)
            CMD_LOAD: begin
              state_nxt = S_FIN;
              if (count_r == CNT_W'(TABLE_DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                res_status_nxt = ST_LOADED;
                mem_wr.en      = 1'b1;
                count_nxt      = count_r + CNT_W'(1);
                if (count_r == '0) begin
                  min_nxt = in_ch.angle;
                  max_nxt = in_ch.angle;
                end else begin
                  if (in_ch.angle < min_r) min_nxt = in_ch.angle;
                  if (in_ch.angle > max_r) max_nxt = in_ch.angle;
                end
              end
            end
            CMD_CLEAR: begin
              state_nxt      = S_FIN;
              res_status_nxt = ST_CLEARED;
              count_nxt      = '0;
              min_nxt        = '0;
              max_nxt        = '0;
            end
            CMD_QUERY: begin
              query_nxt = in_ch.angle;
              if (count_r == '0) begin
                state_nxt      = S_FIN;
                res_status_nxt = ST_EMPTY;
              end else if (in_ch.angle < min_r || in_ch.angle > max_r) begin
                state_nxt      = S_FIN;
                res_status_nxt = ST_OOB;
              end else begin
                state_nxt = S_SCAN;
                issue_nxt = '0;
                ex_ok_nxt = 1'b0;
                lo_ok_nxt = 1'b0;
                hi_ok_nxt = 1'b0;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (issue_r < count_r) begin
          rd_en     = 1'b1;
          pend_nxt  = 1'b1;
          issue_nxt = issue_r + CNT_W'(1);
        end else if (!pend_r) begin
          state_nxt = S_MUL;
        end
        if (pend_r) begin
          if (rd_data.key == query_r && !ex_ok_r) begin
            ex_ok_nxt  = 1'b1;
            ex_val_nxt = rd_data.val;
          end
          if (rd_data.key < query_r && (!lo_ok_r || rd_data.key > lo_key_r)) begin
            lo_ok_nxt  = 1'b1;
            lo_key_nxt = rd_data.key;
            lo_val_nxt = rd_data.val;
          end
          if (rd_data.key > query_r && (!hi_ok_r || rd_data.key < hi_key_r)) begin
            hi_ok_nxt  = 1'b1;
            hi_key_nxt = rd_data.key;
            hi_val_nxt = rd_data.val;
          end
        end
      end
      S_MUL: begin
        if (ex_ok_r) begin
          state_nxt      = S_FIN;
          res_coeff_nxt  = ex_val_r;
          res_status_nxt = ST_EXACT;
        end else if (!lo_ok_r || !hi_ok_r) begin
          state_nxt      = S_FIN;
          res_status_nxt = ST_OOB;
        end else begin
          state_nxt = S_DIVST;
          prod_nxt  = PROD_W'(dq_w) * PROD_W'(dv_w);
          den_nxt   = dk_w[DEN_W-1:0];
        end
      end
      S_DIVST: begin
        neg_nxt   = prod_r[PROD_W-1];
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        state_nxt      = S_FIN;
        res_status_nxt = ST_INTERP;
        if (sum_w > SAT_MAX) begin
          res_coeff_nxt = SAT_MAX[VAL_W-1:0];
        end else if (sum_w < SAT_MIN) begin
          res_coeff_nxt = SAT_MIN[VAL_W-1:0];
        end else begin
          res_coeff_nxt = sum_w[VAL_W-1:0];
        end
      end
      S_FIN: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_coeff_nxt  = res_coeff_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    div_start = (state_r == S_DIVST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      min_r       <= '0;
      max_r       <= '0;
      pend_r      <= 1'b0;
      ex_ok_r     <= 1'b0;
      lo_ok_r     <= 1'b0;
      hi_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      pend_r      <= pend_nxt;
      ex_ok_r     <= ex_ok_nxt;
      lo_ok_r     <= lo_ok_nxt;
      hi_ok_r     <= hi_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
    query_r      <= query_nxt;
    issue_r      <= issue_nxt;
    ex_val_r     <= ex_val_nxt;
    lo_key_r     <= lo_key_nxt;
    lo_val_r     <= lo_val_nxt;
    hi_key_r     <= hi_key_nxt;
    hi_val_r     <= hi_val_nxt;
    prod_r       <= prod_nxt;
    den_r        <= den_nxt;
    neg_r        <= neg_nxt;
    res_coeff_r  <= res_coeff_nxt;
    res_status_r <= res_status_nxt;
    out_coeff_r  <= out_coeff_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.coeff_out = out_coeff_r;
  assign out_ch.status    = out_status_r;

endmodule

// File: hdl/tli_table_mem.sv
// ----------------------------------------------------------------------------
// tli_table_mem
// Key/value table memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tli_table_mem (
  input  logic                   clk,
  input  tli_pkg::mem_wr_t       wr,
  input  logic                   rd_en,
  input  logic [tli_pkg::ADDR_W-1:0] rd_addr,
  output tli_pkg::entry_t        rd_data
);
  import tli_pkg::*;

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/tli_divider.sv
// ----------------------------------------------------------------------------
// tli_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tli_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tli_pkg::DIV_W-1:0] dividend,
  input  logic [tli_pkg::DEN_W-1:0] divisor,
  output logic                      done,
  output logic [tli_pkg::DIV_W-1:0] quotient
);
  import tli_pkg::*;

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DIV_W-1:0]  quot_r, quot_nxt;
  logic [DEN_W:0]    rem_sh;
  logic              fits;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    rem_sh   = {rem_r, quot_r[DIV_W-1]};
    fits     = rem_sh >= {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(DIV_W);
      rem_nxt  = '0;
      den_nxt  = divisor;
      quot_nxt = dividend;
    end else if (busy_r) begin
      rem_nxt  = fits ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
      quot_nxt = {quot_r[DIV_W-2:0], fits};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the table interpolator. A directed table covers
// the empty, out-of-range, exact, duplicate-key and extreme-value cases.
// Random rounds of clears, loads and queries follow, some of which fill the
// table past its depth. Results are compared, field by field, with the values
// given in a directed row or with a behavioral copy of the lookup held here.
// ----------------------------------------------------------------------------
module tb_top;
  import tli_pkg::*;

  localparam int RAND_ITEMS  = 1700;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE      = 150;
  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic signed [15:0] coeff;
    status_e            status;
  } result_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] angle;
    logic signed [15:0] coeff;
    bit                 typed;
    logic signed [15:0] exp_coeff;
    status_e            exp_status;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  tli_in_if  in_ch ();
  tli_out_if out_ch ();

  table_linear_interpolator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic signed [15:0] tbl_key [TABLE_DEPTH];
  logic signed [15:0] tbl_val [TABLE_DEPTH];
  int                 tbl_count;
  logic signed [15:0] tbl_min;
  logic signed [15:0] tbl_max;

  result_t   pending_results [$];
  stim_row_t directed_rows [$];
  int        err_count;
  int        items_done;
  int        stall_cycles;
  bit        no_idle;
  result_t   got_result;
  result_t   want_result;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  task automatic add_row(input stim_row_t r);
    directed_rows = {directed_rows, r};
  endtask

  function automatic bit table_lookup(input logic [1:0] cmd, input logic signed [15:0] ang,
                                      input logic signed [15:0] cin, output result_t res);
    int     i;
    int     lo_i;
    int     hi_i;
    bit     lo_ok;
    bit     hi_ok;
    bit     hit;
    longint num;
    longint den;
    longint mag;
    longint quot;
    longint sum;
    res.coeff    = '0;
    res.status   = ST_EXACT;
    table_lookup = 1'b1;
    case (cmd)
      CMD_LOAD: begin
        if (tbl_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          tbl_key[tbl_count] = ang;
          tbl_val[tbl_count] = cin;
          if (tbl_count == 0) begin
            tbl_min = ang;
            tbl_max = ang;
          end else begin
            if (ang < tbl_min) tbl_min = ang;
            if (ang > tbl_max) tbl_max = ang;
          end
          tbl_count++;
          res.status = ST_LOADED;
        end
      end
      CMD_CLEAR: begin
        tbl_count  = 0;
        tbl_min    = '0;
        tbl_max    = '0;
        res.status = ST_CLEARED;
      end
      CMD_QUERY: begin
        if (tbl_count == 0) begin
          res.status = ST_EMPTY;
        end else if (ang < tbl_min || ang > tbl_max) begin
          res.status = ST_OOB;
        end else begin
          hit = 1'b0;
          for (i = 0; i < tbl_count && !hit; i++) begin
            if (tbl_key[i] == ang) begin
              hit       = 1'b1;
              res.coeff = tbl_val[i];
            end
          end
          if (!hit) begin
            lo_ok = 1'b0;
            hi_ok = 1'b0;
            lo_i  = 0;
            hi_i  = 0;
            for (i = 0; i < tbl_count; i++) begin
              if (tbl_key[i] < ang) begin
                if (!lo_ok || tbl_key[i] > tbl_key[lo_i]) begin
                  lo_i  = i;
                  lo_ok = 1'b1;
                end
              end else if (tbl_key[i] > ang) begin
                if (!hi_ok || tbl_key[i] < tbl_key[hi_i]) begin
                  hi_i  = i;
                  hi_ok = 1'b1;
                end
              end
            end
            if (!lo_ok || !hi_ok) begin
              res.status = ST_OOB;
            end else begin
              num  = (longint'(ang) - longint'(tbl_key[lo_i])) *
                     (longint'(tbl_val[hi_i]) - longint'(tbl_val[lo_i]));
              den  = longint'(tbl_key[hi_i]) - longint'(tbl_key[lo_i]);
              mag  = (num < 0) ? -num : num;
              quot = (mag + den / 2) / den;
              if (num < 0) quot = -quot;
              sum = longint'(tbl_val[lo_i]) + quot;
              if (sum > 32767) sum = 32767;
              if (sum < -32768) sum = -32768;
              res.coeff  = sum[15:0];
              res.status = ST_INTERP;
            end
          end
        end
      end
      default: table_lookup = 1'b0;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic signed [15:0] ang,
                           input logic signed [15:0] cin, input bit typed,
                           input logic signed [15:0] t_coeff, input status_e t_status);
    result_t res;
    while (!no_idle && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= cmd;
    in_ch.angle    <= ang;
    in_ch.coeff_in <= cin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (table_lookup(cmd, ang, cin, res)) begin
      if (typed) begin
        res.coeff  = t_coeff;
        res.status = t_status;
      end
      pending_results = {pending_results, res};
    end
    if (cmd != CMD_NONE) items_done++;
  endtask

  task automatic send_rand(input logic [1:0] cmd, input logic signed [15:0] ang,
                           input logic signed [15:0] cin);
    send_item(cmd, ang, cin, 1'b0, '0, ST_EXACT);
  endtask

  function automatic stim_row_t mk_row(input logic [1:0] cmd, input int ang, input int cin,
                                       input bit typed, input int e_coeff, input status_e e_st);
    stim_row_t r;
    r.cmd        = cmd;
    r.angle      = 16'(ang);
    r.coeff      = 16'(cin);
    r.typed      = typed;
    r.exp_coeff  = 16'(e_coeff);
    r.exp_status = e_st;
    return r;
  endfunction

  always @(posedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(99) >= 14);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_result.coeff = out_ch.coeff_out;
      got_result.status = status_e'(out_ch.status);
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, status", int'(got_result.status), -1);
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.coeff !== want_result.coeff)
          report_mismatch("coeff_out", int'(got_result.coeff), int'(want_result.coeff));
        if (got_result.status !== want_result.status)
          report_mismatch("status", int'(got_result.status), int'(want_result.status));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int                 round;
    int                 k;
    int                 n_load;
    int                 n_query;
    int                 key_mode;
    int                 kind;
    int                 a;
    int                 target;
    logic signed [15:0] key;
    logic signed [15:0] val;
    stim_row_t          row;

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_LOAD;
    in_ch.angle    = '0;
    in_ch.coeff_in = '0;
    items_done     = 0;
    no_idle        = 1'b0;
    tbl_count      = 0;
    tbl_min        = '0;
    tbl_max        = '0;

    add_row(mk_row(CMD_QUERY, 0, 0, 1, 0, ST_EMPTY));
    add_row(mk_row(CMD_NONE, 16'h1234, 16'h5678, 0, 0, ST_EXACT));
    add_row(mk_row(CMD_CLEAR, 0, 0, 1, 0, ST_CLEARED));
    add_row(mk_row(CMD_QUERY, 32767, -1, 1, 0, ST_EMPTY));
    add_row(mk_row(CMD_LOAD, -32768, 32767, 1, 0, ST_LOADED));
    add_row(mk_row(CMD_LOAD, 32767, -32768, 1, 0, ST_LOADED));
    add_row(mk_row(CMD_QUERY, -32768, 0, 1, 32767, ST_EXACT));
    add_row(mk_row(CMD_QUERY, 32767, 0, 1, -32768, ST_EXACT));
    add_row(mk_row(CMD_QUERY, 0, 0, 0, 0, ST_EXACT));
    add_row(mk_row(CMD_QUERY, -1, 0, 0, 0, ST_EXACT));
    add_row(mk_row(CMD_CLEAR, -1, -1, 1, 0, ST_CLEARED));
    add_row(mk_row(CMD_LOAD, -256, 100, 1, 0, ST_LOADED));
    add_row(mk_row(CMD_LOAD, 256, 4196, 1, 0, ST_LOADED));
    add_row(mk_row(CMD_QUERY, -257, 0, 1, 0, ST_OOB));
    add_row(mk_row(CMD_QUERY, 257, 0, 1, 0, ST_OOB));
    add_row(mk_row(CMD_QUERY, -256, 0, 1, 100, ST_EXACT));
    add_row(mk_row(CMD_LOAD, 0, 55, 1, 0, ST_LOADED));
    add_row(mk_row(CMD_LOAD, 0, 77, 1, 0, ST_LOADED));
    add_row(mk_row(CMD_QUERY, 0, 0, 1, 55, ST_EXACT));
    add_row(mk_row(CMD_LOAD, 128, 1000, 1, 0, ST_LOADED));
    add_row(mk_row(CMD_LOAD, 128, -1000, 1, 0, ST_LOADED));
    add_row(mk_row(CMD_QUERY, 64, 0, 0, 0, ST_EXACT));
    add_row(mk_row(CMD_QUERY, 200, 0, 0, 0, ST_EXACT));
    add_row(mk_row(CMD_NONE, -1, -1, 0, 0, ST_EXACT));
    add_row(mk_row(CMD_QUERY, 1, 0, 0, 0, ST_EXACT));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_item(row.cmd, row.angle, row.coeff, row.typed, row.exp_coeff, row.exp_status);
    end

    // Rounds of clear, load and query. Most rounds keep the table small so
    // that queries stay short; a few fill it past its depth.
    round = 0;
    target = items_done + RAND_ITEMS;
    while (items_done < target) begin
      round++;
      if (round % 9 == 4) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      no_idle = (items_done >= target - 1000) && (items_done < target - 700);
      key_mode = $urandom_range(3);
      if ($urandom_range(9) != 0) send_rand(CMD_CLEAR, 16'($urandom), 16'($urandom));
      if ($urandom_range(5) == 0) send_rand(CMD_QUERY, 16'($urandom), 16'($urandom));
      n_load = ($urandom_range(11) == 0) ? TABLE_DEPTH + 1 + $urandom_range(2)
                                         : 2 + $urandom_range(10);
      for (k = 0; k < n_load; k++) begin
        case (key_mode)
          0: key = 16'($urandom);
          1: key = 16'(int'($urandom_range(32)) - 16);
          2: key = 16'(int'($urandom_range(2047)) - 1024);
          default: key = 16'(-30000 + (k % 64) * 930 + int'($urandom_range(40)));
        endcase
        if ($urandom_range(7) == 0) val = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        else val = 16'($urandom);
        if ($urandom_range(19) == 0) send_rand(CMD_NONE, 16'($urandom), 16'($urandom));
        send_rand(CMD_LOAD, key, val);
      end
      n_query = 4 + $urandom_range(12);
      for (k = 0; k < n_query; k++) begin
        kind = $urandom_range(99);
        if (tbl_count == 0 || kind >= 95) begin
          a = int'($signed(16'($urandom)));
        end else if (kind < 30) begin
          a = int'(tbl_key[$urandom_range(tbl_count - 1)]);
        end else if (kind < 75) begin
          a = int'(tbl_min) + int'($urandom_range(int'(tbl_max) - int'(tbl_min)));
        end else if (kind < 87) begin
          if ($urandom_range(1) && tbl_min > -32768) begin
            a = int'(tbl_min) - 1 - int'($urandom_range(7));
            if (a < -32768) a = -32768;
          end else if (tbl_max < 32767) begin
            a = int'(tbl_max) + 1 + int'($urandom_range(7));
            if (a > 32767) a = 32767;
          end else begin
            a = int'($signed(16'($urandom)));
          end
        end else if (kind < 90) begin
          send_rand(CMD_NONE, 16'($urandom), 16'($urandom));
          a = int'(tbl_min) + int'($urandom_range(int'(tbl_max) - int'(tbl_min)));
        end else begin
          a = int'($signed(16'($urandom)));
        end
        send_rand(CMD_QUERY, 16'(a), 16'($urandom));
      end
    end
    no_idle = 1'b0;
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 0, pending_results.size());

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
